// ===== src/sspc_pkg.sv =====
package sspc_pkg;

	localparam int MODE_W = 3;
	localparam int BYTE_W = 8;
	localparam int LOW_W  = 7;
	localparam int SUM_W  = 16;
	localparam int FILL_W = 3;

	// a full group holds seven bytes, the last slot index is six
	localparam logic [FILL_W-1:0] GROUP_N   = 3'd7;
	localparam logic [FILL_W-1:0] FILL_LAST = 3'd6;

	// trailer: sum hi, sum lo, len hi, len lo, end of exclusive
	localparam logic [FILL_W-1:0] TRL_LAST = 3'd4;
	localparam logic [SUM_W-1:0]  LEN_BIAS = 16'd5;
	localparam logic [BYTE_W-1:0] EOX_BYTE = 8'hF7;

	typedef enum logic [MODE_W-1:0] {
		MODE_DATA       = 3'd0,
		MODE_FLUSH      = 3'd1,
		MODE_SUM_START  = 3'd2,
		MODE_SUM_FINISH = 3'd3,
		MODE_RAW        = 3'd4,
		MODE_SEVEN      = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		SEL_RAW,
		SEL_HDR,
		SEL_LOW,
		SEL_SUM_HI,
		SEL_SUM_LO,
		SEL_LEN_HI,
		SEL_LEN_LO,
		SEL_EOX
	} sel_t;

	typedef struct packed {
		logic              load;
		logic              emit;
		sel_t              sel;
		logic [FILL_W-1:0] low_idx;
		logic              last;
	} dp_cmd_t;

	typedef struct packed {
		logic              seven_bit_on;
		logic [FILL_W-1:0] fill;
		logic              out_free;
	} dp_stat_t;

endpackage

// ===== src/sspc_cmd_if.sv =====
interface sspc_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [sspc_pkg::MODE_W-1:0] mode;
	logic [sspc_pkg::BYTE_W-1:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink (input valid, input mode, input data_byte, output ready);
endinterface

// ===== src/sspc_byte_if.sv =====
interface sspc_byte_if;
	logic                         valid;
	logic                         ready;
	logic [sspc_pkg::BYTE_W-1:0] out_byte;
	logic                         last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== src/sspc_dp.sv =====
module sspc_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sspc_pkg::dp_cmd_t            cmd,
	input  logic [sspc_pkg::MODE_W-1:0] mode,
	input  logic [sspc_pkg::BYTE_W-1:0] data_byte,
	output sspc_pkg::dp_stat_t           stat,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sspc_pkg::BYTE_W-1:0] out_byte,
	output logic                         last
);
	import sspc_pkg::*;

	mode_t             mode_v;
	logic              seven_q;
	logic              sum_on_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sent_q;
	logic [SUM_W-1:0]  len_q;
	logic [FILL_W-1:0] fill_q;
	logic [LOW_W-1:0]  top_q;
	logic [LOW_W-1:0]  top_nxt;
	logic [LOW_W-1:0]  pend_q [GROUP_N];
	logic [BYTE_W-1:0] data_q;
	logic              ovalid_q;
	logic [BYTE_W-1:0] obyte_q;
	logic              olast_q;
	logic [BYTE_W-1:0] emit_byte;
	logic              out_free;

	assign mode_v   = mode_t'(mode);
	assign out_free = !ovalid_q || out_ready;

	assign stat.seven_bit_on = seven_q;
	assign stat.fill         = fill_q;
	assign stat.out_free     = out_free;

	assign out_valid = ovalid_q;
	assign out_byte  = obyte_q;
	assign last      = olast_q;

	// first byte of a group lands at bit 6
	always_comb begin
		top_nxt = (fill_q == '0) ? '0 : top_q;
		top_nxt[FILL_LAST - fill_q] = data_byte[BYTE_W-1];
	end

	always_comb begin
		case (cmd.sel)
			SEL_RAW:    emit_byte = data_q;
			SEL_HDR:    emit_byte = {1'b0, top_q};
			SEL_LOW:    emit_byte = {1'b0, pend_q[cmd.low_idx]};
			SEL_SUM_HI: emit_byte = {1'b0, sum_q[2*LOW_W-1:LOW_W]};
			SEL_SUM_LO: emit_byte = {1'b0, sum_q[LOW_W-1:0]};
			SEL_LEN_HI: emit_byte = {1'b0, len_q[2*LOW_W-1:LOW_W]};
			SEL_LEN_LO: emit_byte = {1'b0, len_q[LOW_W-1:0]};
			default:    emit_byte = EOX_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seven_q  <= 1'b1;
			sum_on_q <= 1'b0;
			sum_q    <= '0;
			sent_q   <= '0;
			fill_q   <= '0;
			top_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				ovalid_q <= 1'b1;
				sent_q   <= sent_q + 16'd1;
				if (sum_on_q) begin
					sum_q <= sum_q + {{(SUM_W-BYTE_W){1'b0}}, emit_byte};
				end
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (cmd.load) begin
				unique case (mode_v)
					MODE_DATA: begin
						if (seven_q) begin
							top_q  <= top_nxt;
							fill_q <= (fill_q == FILL_LAST) ? '0 : fill_q + 3'd1;
						end
					end
					MODE_FLUSH: begin
						fill_q <= '0;
					end
					MODE_SUM_START: begin
						sum_q    <= '0;
						sum_on_q <= 1'b1;
					end
					MODE_SUM_FINISH: begin
						sum_on_q <= 1'b0;
						fill_q   <= '0;
						seven_q  <= 1'b0;
					end
					MODE_RAW: begin
						fill_q  <= '0;
						seven_q <= 1'b0;
					end
					MODE_SEVEN: begin
						fill_q  <= '0;
						seven_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			data_q <= data_byte;
			if (mode_v == MODE_DATA && seven_q) begin
				pend_q[fill_q] <= data_byte[LOW_W-1:0];
			end
			if (mode_v == MODE_SUM_FINISH) begin
				len_q <= sent_q - LEN_BIAS;
			end
		end
		if (cmd.emit) begin
			obyte_q <= emit_byte;
			olast_q <= cmd.last;
		end
	end

	a_seven_clears_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && mode_v == MODE_SEVEN |=> seven_q && fill_q == '0)
		else $error("seven-bit mode did not clear the group");

	a_sum_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && mode_v == MODE_SUM_START |=> sum_on_q && sum_q == '0)
		else $error("checksum start did not clear the sum");

	a_emit_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> ovalid_q)
		else $error("emitted byte not held in output register");

endmodule

// ===== src/sspc_ctrl.sv =====
module sspc_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [sspc_pkg::MODE_W-1:0] mode,
	output logic                         in_ready,
	input  sspc_pkg::dp_stat_t           stat,
	output sspc_pkg::dp_cmd_t            cmd
);
	import sspc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RAW,
		S_HDR,
		S_LOW,
		S_TRL
	} state_t;

	state_t            state_q;
	mode_t             mode_v;
	logic [FILL_W-1:0] cnt_q;
	logic [FILL_W-1:0] idx_q;
	logic              trl_q;
	logic              accept;
	logic              low_last;

	assign mode_v   = mode_t'(mode);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign low_last = (idx_q == cnt_q - 3'd1);

	always_comb begin
		cmd.load    = accept;
		cmd.emit    = 1'b0;
		cmd.sel     = SEL_RAW;
		cmd.low_idx = idx_q;
		cmd.last    = 1'b0;
		unique case (state_q)
			S_RAW: begin
				cmd.emit = stat.out_free;
				cmd.last = 1'b1;
			end
			S_HDR: begin
				cmd.emit = stat.out_free;
				cmd.sel  = SEL_HDR;
			end
			S_LOW: begin
				cmd.emit = stat.out_free;
				cmd.sel  = SEL_LOW;
				cmd.last = low_last && !trl_q;
			end
			S_TRL: begin
				cmd.emit = stat.out_free;
				cmd.last = (idx_q == TRL_LAST);
				case (idx_q)
					3'd0:    cmd.sel = SEL_SUM_HI;
					3'd1:    cmd.sel = SEL_SUM_LO;
					3'd2:    cmd.sel = SEL_LEN_HI;
					3'd3:    cmd.sel = SEL_LEN_LO;
					default: cmd.sel = SEL_EOX;
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			trl_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						unique case (mode_v) inside
							MODE_DATA: begin
								if (!stat.seven_bit_on) begin
									state_q <= S_RAW;
								end else if (stat.fill == FILL_LAST) begin
									cnt_q   <= GROUP_N;
									trl_q   <= 1'b0;
									state_q <= S_HDR;
								end
							end
							MODE_FLUSH, MODE_RAW: begin
								if (stat.fill != '0) begin
									cnt_q   <= stat.fill;
									trl_q   <= 1'b0;
									state_q <= S_HDR;
								end
							end
							MODE_SUM_FINISH: begin
								trl_q <= 1'b1;
								if (stat.fill != '0) begin
									cnt_q   <= stat.fill;
									state_q <= S_HDR;
								end else begin
									state_q <= S_TRL;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RAW: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_HDR: begin
					if (stat.out_free) begin
						state_q <= S_LOW;
					end
				end
				S_LOW: begin
					if (stat.out_free) begin
						if (low_last) begin
							idx_q   <= '0;
							state_q <= trl_q ? S_TRL : S_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				S_TRL: begin
					if (stat.out_free) begin
						if (idx_q == TRL_LAST) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("byte emitted into a full output register");

	a_low_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOW |-> idx_q < cnt_q)
		else $error("low byte index beyond group length");

	a_finish_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode_v == MODE_SUM_FINISH |=> state_q == S_HDR || state_q == S_TRL)
		else $error("checksum finish did not start its output");

endmodule

// ===== src/sysex_seven_bit_packer_checksum.sv =====
// sysex seven-bit packer with running checksum. each command beat carries a
// mode and a data byte; the block answers with zero or more output beats, the
// final one of each command marked by last. in seven-bit mode data bytes are
// gathered in groups of seven and sent as a header byte of top bits (first
// byte at bit 6) followed by the low seven bits of each byte; a flush sends a
// partial group the same way. in raw mode bytes pass through unchanged.
// checksum start clears the 16-bit sum and enables it; checksum finish
// flushes the group, goes to raw mode and sends sum hi, sum lo, count-5 hi,
// count-5 lo and 0xF7. after a command is accepted its bytes follow one per
// cycle through the single output register while that register is free;
// a stalled output beat holds the controller until it is taken; commands are
// accepted only while the controller is idle.
module sysex_seven_bit_packer_checksum (
	input logic       clk,
	input logic       arst_n,
	sspc_cmd_if.sink  cmd,
	sspc_byte_if.source stream
);
	import sspc_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// sequencer: decides how many bytes each command produces and in what order
	sspc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.mode     (cmd.mode),
		.in_ready (cmd.ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// datapath: group buffer, header bits, sum, byte count and output register
	sspc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.mode      (cmd.mode),
		.data_byte (cmd.data_byte),
		.stat      (dp_stat),
		.out_valid (stream.valid),
		.out_ready (stream.ready),
		.out_byte  (stream.out_byte),
		.last      (stream.last)
	);

endmodule
